[hw/rtl/dsmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsmq_pkg
// Shared types, widths and codes for the deadline sorted message queue.
// ----------------------------------------------------------------------------
package dsmq_pkg;

    localparam int DSMQ_DEPTH = 16;

    localparam int OP_W     = 2;
    localparam int TAG_W    = 16;
    localparam int DELAY_W  = 32;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] EMPTY_WAIT_RESET = CFG_W'(1000);

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL = 2'd2;
    localparam logic [OP_W-1:0] OP_QUIT = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJ_QUIT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJ_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd6;

    // one queue slot
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic              enq;
        logic              pop;
        logic              clr;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_cell_cmd;

endpackage
`default_nettype wire

[hw/rtl/deadline_sorted_message_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_sorted_message_queue
// Timed message queue kept in deadline order by a chain of compare cells.
// ----------------------------------------------------------------------------
// Each input word is one operation: tick (advance the ms counter), enqueue,
// poll or quit; each produces exactly one result word. A word is captured
// into the capture register (deadline = now + delay, or 0 for zero delay)
// and executed once the output register can take its result, where every
// cell of the chain compares its deadline against the new one in parallel
// and the chain inserts, pops or clears in place. The block holds one word
// in flight, so it takes no new word until the last one has executed. A
// stalled result stays in the output register while the next word is captured.
// Queue order: ties keep arrival order. A poll on an empty queue reports
// the empty_wait_ms register (0 reads as 1); waits beyond 32 bits saturate.
// ----------------------------------------------------------------------------
module deadline_sorted_message_queue #(
    parameter int QUEUE_DEPTH = dsmq_pkg::DSMQ_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [dsmq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input words
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [dsmq_pkg::OP_W-1:0]     i_op,
    input  wire logic [dsmq_pkg::TAG_W-1:0]    i_tag,
    input  wire logic [dsmq_pkg::DELAY_W-1:0]  i_delay_ms,
    // result words
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [dsmq_pkg::STATUS_W-1:0]      o_status,
    output logic [dsmq_pkg::TAG_W-1:0]         o_out_tag,
    output logic [dsmq_pkg::DELAY_W-1:0]       o_wait_ms
);
    import dsmq_pkg::*;

    // config and global state
    logic [CFG_W-1:0]    r_empty_wait;
    logic [TIME_W-1:0]   r_now;
    logic                r_stopped;

    // capture stage
    logic                r_busy;
    logic [OP_W-1:0]     r_op;
    logic [TAG_W-1:0]    r_tag;
    logic [TIME_W-1:0]   r_deadline;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [TAG_W-1:0]    r_out_tag;
    logic [DELAY_W-1:0]  r_wait;

    logic [STATUS_W-1:0] n_status;
    logic [TAG_W-1:0]    n_out_tag;
    logic [DELAY_W-1:0]  n_wait;
    logic                n_tick;
    logic                n_quit;

    logic                w_accept;
    logic                w_exec;
    logic [TIME_W-1:0]   w_diff;
    t_cell_cmd           w_cmd;

    t_entry              w_entry [QUEUE_DEPTH];
    logic                w_keep  [QUEUE_DEPTH];

    localparam t_entry EMPTY_ENTRY = '{valid: 1'b0, deadline: '0, tag: '0};

    assign o_stall   = r_busy;
    assign w_accept  = i_valid && !r_busy;
    assign w_exec    = r_busy && (!r_out_valid || !i_stall);

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_out_tag = r_out_tag;
    assign o_wait_ms = r_wait;

    // cell chain; cell 0 is the queue front
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_keep;

            if (gi == 0) begin : g_head
                assign w_prev      = EMPTY_ENTRY;
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev      = w_entry[gi-1];
                assign w_prev_keep = w_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = EMPTY_ENTRY;
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            dsmq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_prev      (w_prev),
                .i_prev_keep (w_prev_keep),
                .i_next      (w_next),
                .o_entry     (w_entry[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    // time left until the front word is due
    assign w_diff = w_entry[0].deadline - r_now;

    // execute: decode the captured word against the chain front
    always_comb begin
        w_cmd          = '0;
        w_cmd.deadline = r_deadline;
        w_cmd.tag      = r_tag;
        n_status       = ST_DONE;
        n_out_tag      = '0;
        n_wait         = '0;
        n_tick         = 1'b0;
        n_quit         = 1'b0;
        unique case (r_op)
            OP_TICK: begin
                n_tick = 1'b1;
            end
            OP_ENQ: begin
                if (r_stopped) begin
                    n_status = ST_REJ_QUIT;
                end else if (w_entry[QUEUE_DEPTH-1].valid) begin
                    n_status = ST_REJ_FULL;
                end else begin
                    n_status  = ST_ENQUEUED;
                    w_cmd.enq = w_exec;
                end
            end
            OP_POLL: begin
                if (r_stopped) begin
                    n_status  = ST_STOPPED;
                    w_cmd.clr = w_exec;
                end else if (!w_entry[0].valid) begin
                    n_status = ST_WAIT;
                    n_wait   = (r_empty_wait == '0) ? DELAY_W'(1)
                                                    : DELAY_W'(r_empty_wait);
                end else if (r_now < w_entry[0].deadline) begin
                    n_status = ST_WAIT;
                    n_wait   = (w_diff[TIME_W-1:DELAY_W] != '0) ? '1
                                                                : w_diff[DELAY_W-1:0];
                end else begin
                    n_status  = ST_DELIVERED;
                    n_out_tag = w_entry[0].tag;
                    w_cmd.pop = w_exec;
                end
            end
            OP_QUIT: begin
                n_quit = 1'b1;
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_now        <= '0;
            r_stopped    <= 1'b0;
            r_empty_wait <= EMPTY_WAIT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_empty_wait <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_exec && n_tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (w_exec && n_quit) begin
                r_stopped <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_op;
            r_tag      <= i_tag;
            r_deadline <= (i_delay_ms == '0) ? '0 : r_now + TIME_W'(i_delay_ms);
        end
        if (w_exec) begin
            r_status  <= n_status;
            r_out_tag <= n_out_tag;
            r_wait    <= n_wait;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/dsmq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsmq_cell
// One slot of the sorted chain: holds, takes the new word, shifts, or clears.
// ----------------------------------------------------------------------------
module dsmq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dsmq_pkg::t_cell_cmd i_cmd,
    input  wire dsmq_pkg::t_entry   i_prev,
    input  wire logic               i_prev_keep,
    input  wire dsmq_pkg::t_entry   i_next,
    output dsmq_pkg::t_entry        o_entry,
    output logic                    o_keep
);
    import dsmq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // slot stays put on insert when its deadline is not later than the new one
    assign o_keep  = r_entry.valid && (r_entry.deadline <= i_cmd.deadline);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.clr) begin
            n_entry.valid = 1'b0;
        end else if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.enq && !o_keep) begin
            if (i_prev_keep) begin
                n_entry.valid    = 1'b1;
                n_entry.deadline = i_cmd.deadline;
                n_entry.tag      = i_cmd.tag;
            end else begin
                n_entry = i_prev;
            end
        end
    end

    // only the valid bit is reset; payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.deadline <= n_entry.deadline;
        r_entry.tag      <= n_entry.tag;
    end

endmodule
`default_nettype wire
